// ===== rtl/apsp_pkg.sv =====
// Package for the all-pairs shortest path core: sizes, command codes,
// result kinds and sequencer states.
// No dependencies; imported by all_pairs_shortest_path_core.
package apsp_pkg;

  // Store geometry
  localparam int MaxNodes = 16;
  localparam int NodeW    = $clog2(MaxNodes);
  localparam int AddrW    = 2 * NodeW;
  localparam int Depth    = MaxNodes * MaxNodes;

  // Field widths
  localparam int DistW = 32;
  localparam int PredW = 5;
  localparam int CntW  = $clog2(MaxNodes + 1);

  // Configuration port
  localparam int PaddrW = 3;
  localparam int PdataW = 32;

  typedef logic signed [DistW-1:0] dist_t;
  typedef logic [PredW-1:0]        pred_t;
  typedef logic [NodeW-1:0]        node_t;
  typedef logic [AddrW-1:0]        addr_t;
  typedef logic [CntW-1:0]         cnt_t;

  // Command codes
  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_RUN  = 2'd1,
    ACT_READ = 2'd2
  } action_t;

  // Result kinds
  typedef enum logic {
    KIND_RUN  = 1'b0,
    KIND_READ = 1'b1
  } kind_t;

  // Relaxation sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW_RD,
    ST_ROW_CAP,
    ST_J_RD,
    ST_J_UPD,
    ST_DONE
  } state_t;

  // Register index of node_count
  localparam logic REG_NODE_COUNT = 1'b0;

  // Row-major entry address
  function automatic addr_t cell_addr(input node_t row, input node_t col);
    return {row, col};
  endfunction

endpackage

// ===== rtl/all_pairs_shortest_path_core.sv =====
// A load writes at its transfer; a read result goes through the port A read register, then
// the result register. Loads and reads are taken one per cycle unless a read result stalls.
// A run walks n = min(node_count,16) nodes: per (k,i) it reads and captures d[i][k], per j it
// reads d[k][j], then writes d[i][j] if the path through k is shorter; no other command is taken meanwhile.
// Reset (synchronous, rst_n low): control cleared, node_count = 16; the distance and
// predecessor memories are not cleared and hold nothing valid until loaded.
module all_pairs_shortest_path_core
  import apsp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // Command channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_action,
  input  logic [NodeW-1:0]        in_row,
  input  logic [NodeW-1:0]        in_col,
  input  logic signed [DistW-1:0] in_cost,
  input  logic [PredW-1:0]        in_pred_in,
  // Result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_result_kind,
  output logic signed [DistW-1:0] out_distance,
  output logic [PredW-1:0]        out_predecessor,
  // Configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PaddrW-1:0]       paddr,
  input  logic [PdataW-1:0]       pwdata,
  output logic [PdataW-1:0]       prdata,
  output logic                    pready
);

  // Memories
  dist_t dist_mem [Depth];
  pred_t pred_mem [Depth];

  // Registers
  state_t state_r, state_nxt;
  cnt_t   node_count_r;
  node_t  k_r, k_nxt, i_r, i_nxt, j_r, j_nxt;
  dist_t  dik_r, dik_nxt;
  dist_t  rda_r, rdb_r;
  pred_t  rpa_r;
  logic   rd_pend_r, rd_pend_nxt;
  logic   out_valid_r, out_valid_nxt;
  kind_t  out_kind_r, out_kind_nxt;
  dist_t  out_dist_r, out_dist_nxt;
  pred_t  out_pred_r, out_pred_nxt;

  // Memory port controls
  logic   rd_en_a;
  addr_t  ra_addr, rb_addr, wr_addr;
  logic   wr_en;
  dist_t  wr_dist;
  pred_t  wr_pred;

  // Misc
  logic   in_xfer, out_free, cfg_wr;
  cnt_t   n_eff, n_last;
  logic   j_last, i_last, k_last;
  logic   [DistW:0] sum_wide;
  dist_t  sum_sat;
  logic   relax;

  // ---------------------------------------------------------------------------
  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= cnt_t'(MaxNodes);
    end else if (cfg_wr && paddr[2] == REG_NODE_COUNT) begin
      node_count_r <= pwdata[CntW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_NODE_COUNT) begin
      prdata = {{(PdataW-CntW){1'b0}}, node_count_r};
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake and loop bounds
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && (!rd_pend_r || out_free);
  assign in_xfer  = in_valid && in_ready;

  assign n_eff  = (node_count_r > cnt_t'(MaxNodes)) ? cnt_t'(MaxNodes) : node_count_r;
  assign n_last = n_eff - cnt_t'(1);
  assign j_last = ({1'b0, j_r} == n_last);
  assign i_last = ({1'b0, i_r} == n_last);
  assign k_last = ({1'b0, k_r} == n_last);

  // Path through k: widened sum, saturated, strict compare
  assign sum_wide = {dik_r[DistW-1], dik_r} + {rda_r[DistW-1], rda_r};
  always_comb begin
    sum_sat = sum_wide[DistW-1:0];
    if (sum_wide[DistW] != sum_wide[DistW-1]) begin
      sum_sat = sum_wide[DistW] ? {1'b1, {(DistW-1){1'b0}}} : {1'b0, {(DistW-1){1'b1}}};
    end
  end
  assign relax = (rdb_r > sum_sat);

  // ---------------------------------------------------------------------------
  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_action == ACT_RUN) begin
          state_nxt = (n_eff == '0) ? ST_DONE : ST_ROW_RD;
        end
      end
      ST_ROW_RD:  state_nxt = ST_ROW_CAP;
      ST_ROW_CAP: state_nxt = ST_J_RD;
      ST_J_RD:    state_nxt = ST_J_UPD;
      ST_J_UPD: begin
        if (!j_last) begin
          state_nxt = ST_J_RD;
        end else if (i_last && k_last) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_ROW_RD;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer outputs: memory ports, loop counters, forwarded d[i][k]
  always_comb begin
    rd_en_a = 1'b0;
    ra_addr = cell_addr(in_row, in_col);
    rb_addr = cell_addr(i_r, j_r);
    wr_en   = 1'b0;
    wr_addr = cell_addr(in_row, in_col);
    wr_dist = (in_row == in_col) ? '0 : in_cost;
    wr_pred = in_pred_in;
    k_nxt   = k_r;
    i_nxt   = i_r;
    j_nxt   = j_r;
    dik_nxt = dik_r;
    case (state_r)
      ST_IDLE: begin
        k_nxt = '0;
        i_nxt = '0;
        j_nxt = '0;
        if (in_xfer && in_action == ACT_LOAD) begin
          wr_en = 1'b1;
        end
        if (in_xfer && in_action == ACT_READ) begin
          rd_en_a = 1'b1;
        end
      end
      ST_ROW_RD: begin
        rd_en_a = 1'b1;
        ra_addr = cell_addr(i_r, k_r);
      end
      ST_ROW_CAP: begin
        dik_nxt = rda_r;
      end
      ST_J_RD: begin
        rd_en_a = 1'b1;
        ra_addr = cell_addr(k_r, j_r);
      end
      ST_J_UPD: begin
        wr_addr = cell_addr(i_r, j_r);
        wr_dist = sum_sat;
        wr_pred = rpa_r;
        if (relax) begin
          wr_en = 1'b1;
          // d[i][k] itself is replaced when j reaches k
          if (j_r == k_r) begin
            dik_nxt = sum_sat;
          end
        end
        if (!j_last) begin
          j_nxt = j_r + node_t'(1);
        end else begin
          j_nxt = '0;
          if (!i_last) begin
            i_nxt = i_r + node_t'(1);
          end else begin
            i_nxt = '0;
            k_nxt = k_r + node_t'(1);
          end
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result register: read data first, then run completion
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_dist_nxt  = out_dist_r;
    out_pred_nxt  = out_pred_r;
    if (rd_pend_r && out_free) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = KIND_READ;
      out_dist_nxt  = rda_r;
      out_pred_nxt  = rpa_r;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = KIND_RUN;
      out_dist_nxt  = '0;
      out_pred_nxt  = '0;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    rd_pend_nxt = rd_pend_r;
    if (in_xfer && in_action == ACT_READ) begin
      rd_pend_nxt = 1'b1;
    end else if (out_free) begin
      rd_pend_nxt = 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_distance    = out_dist_r;
  assign out_predecessor = out_pred_r;

  // ---------------------------------------------------------------------------
  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    dik_r      <= dik_nxt;
    out_kind_r <= out_kind_nxt;
    out_dist_r <= out_dist_nxt;
    out_pred_r <= out_pred_nxt;
  end

  // ---------------------------------------------------------------------------
  // Distance memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      dist_mem[wr_addr] <= wr_dist;
    end
    if (rd_en_a) begin
      rda_r <= dist_mem[ra_addr];
    end
    rdb_r <= dist_mem[rb_addr];
  end

  // Predecessor memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pred_mem[wr_addr] <= wr_pred;
    end
    if (rd_en_a) begin
      rpa_r <= pred_mem[ra_addr];
    end
  end

  // ---------------------------------------------------------------------------
`ifndef SYNTHESIS
  // Port A read data is never reused by a run while a read result still waits
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !rd_pend_r)
    else $error("read result pending during relaxation");

  // A stalled read result keeps its memory data until it moves to the output
  assert property (@(posedge clk) disable iff (!rst_n)
    (rd_pend_r && !out_free) |=> (rd_pend_r && $stable(rda_r) && $stable(rpa_r)))
    else $error("pending read data lost");

  // Leaving the done state always presents a run completion
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> (out_valid_r && out_kind_r == KIND_RUN))
    else $error("run completion not presented");
`endif

endmodule

// ===== dv/all_pairs_shortest_path_core_tb.sv =====
// Self-checking testbench for all_pairs_shortest_path_core: directed table, then random graphs
// loaded, closed and read back, checked against an in-bench shortest-path predictor.
// Depends on rtl/apsp_pkg.sv and rtl/all_pairs_shortest_path_core.sv.
module all_pairs_shortest_path_core_tb;
  import apsp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Command code with no meaning; the core drops it
  localparam logic [1:0] ActNone = 2'd3;

  localparam logic [PaddrW-1:0] NodeCountAddr = PaddrW'(4 * int'(REG_NODE_COUNT));

  localparam dist_t   DistHi   = {1'b0, {(DistW-1){1'b1}}};
  localparam dist_t   DistLo   = {1'b1, {(DistW-1){1'b0}}};
  localparam dist_t   NoEdge   = DistHi;
  localparam longint  SumMax   = (64'sd1 <<< (DistW - 1)) - 1;
  localparam longint  SumMin   = -SumMax - 1;

  // A full 16-node closure is the longest quiet stretch
  localparam int RunCyclesMax = MaxNodes * MaxNodes * (2 * MaxNodes + 2) + 2;
  localparam int QuietLimit   = 4 * RunCyclesMax + 1000;
  localparam int IdleSettle   = 4;
  localparam int EndWait      = 16;
  localparam int ItemTarget   = 1300;

  typedef struct packed {
    logic [1:0] action;
    node_t      row;
    node_t      col;
    dist_t      cost;
    pred_t      pred;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    dist_t distance;
    pred_t pred;
  } result_t;

  typedef struct packed {
    cmd_t    cmd;
    logic    typed;
    result_t want;
  } step_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              in_action = '0;
  logic [NodeW-1:0]        in_row = '0;
  logic [NodeW-1:0]        in_col = '0;
  logic signed [DistW-1:0] in_cost = '0;
  logic [PredW-1:0]        in_pred_in = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    out_result_kind;
  logic signed [DistW-1:0] out_distance;
  logic [PredW-1:0]        out_predecessor;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [PaddrW-1:0]       paddr = '0;
  logic [PdataW-1:0]       pwdata = '0;
  logic [PdataW-1:0]       prdata;
  logic                    pready;

  // Predictor state: distance and predecessor matrices plus node count
  dist_t      path_len [Depth];
  pred_t      path_prev[Depth];
  logic [4:0] node_cfg = 5'd16;

  result_t pending_results[$];
  step_t   directed_steps[$];

  int idle_mode = 0;
  int mismatch_count = 0;
  int items_sent = 0;
  int runs_sent = 0;
  int settings_used = 0;
  int results_checked = 0;
  int quiet_cycles = 0;

  all_pairs_shortest_path_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_cost         (in_cost),
    .in_pred_in      (in_pred_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_distance    (out_distance),
    .out_predecessor (out_predecessor),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic int sender_gap_pct();
    if (idle_mode == 1) return 66;
    if (idle_mode == 3) return 12;
    return 0;
  endfunction

  function automatic int receiver_stall_pct();
    if (idle_mode == 2) return 66;
    if (idle_mode == 3) return 12;
    return 0;
  endfunction

  // In-place Floyd-Warshall over the first min(node_cfg,16) nodes, sums saturated
  function automatic void relax_all_pairs();
    int n;
    int ij;
    longint s;
    n = (node_cfg > MaxNodes) ? MaxNodes : int'(node_cfg);
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < n; j++) begin
          ij = i * MaxNodes + j;
          s = longint'(path_len[i * MaxNodes + k]) + longint'(path_len[k * MaxNodes + j]);
          if (s > SumMax) s = SumMax;
          if (s < SumMin) s = SumMin;
          if (longint'(path_len[ij]) > s) begin
            path_len[ij]  = dist_t'(s);
            path_prev[ij] = path_prev[k * MaxNodes + j];
          end
        end
      end
    end
  endfunction

  // Apply one command to the predictor; returns 1 when it yields a result
  function automatic bit predict_command(input cmd_t c, output result_t r);
    int idx;
    idx = int'(c.row) * MaxNodes + int'(c.col);
    r = '0;
    case (c.action)
      ACT_LOAD: begin
        path_len[idx]  = (c.row == c.col) ? dist_t'(0) : c.cost;
        path_prev[idx] = c.pred;
        return 1'b0;
      end
      ACT_RUN: begin
        relax_all_pairs();
        r.kind = KIND_RUN;
        return 1'b1;
      end
      ACT_READ: begin
        r.kind     = KIND_READ;
        r.distance = path_len[idx];
        r.pred     = path_prev[idx];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic cmd_t make_cmd(input logic [1:0] act, input int r, input int c,
                                    input dist_t cost, input pred_t p);
    cmd_t m;
    m.action = act;
    m.row    = node_t'(r);
    m.col    = node_t'(c);
    m.cost   = cost;
    m.pred   = p;
    return m;
  endfunction

  function automatic void add_step(input logic [1:0] act, input int r, input int c,
                                   input dist_t cost, input pred_t p, input bit typed = 1'b0,
                                   input kind_t k = KIND_RUN, input dist_t d = '0,
                                   input pred_t wp = '0);
    step_t s;
    s.cmd           = make_cmd(act, r, c, cost, p);
    s.typed         = typed;
    s.want.kind     = k;
    s.want.distance = d;
    s.want.pred     = wp;
    directed_steps.push_back(s);
  endfunction

  // Random edge of a well-formed graph, with some full-range noise
  function automatic cmd_t graph_entry(input int r, input int c);
    int p;
    p = $urandom_range(99);
    if (p < 48) return make_cmd(ACT_LOAD, r, c, dist_t'($urandom_range(100)), pred_t'(r + 1));
    if (p < 80) return make_cmd(ACT_LOAD, r, c, NoEdge, '0);
    if (p < 86) return make_cmd(ACT_LOAD, r, c, -dist_t'($urandom_range(20, 1)), pred_t'(r + 1));
    return make_cmd(ACT_LOAD, r, c, dist_t'($urandom), pred_t'($urandom_range(31)));
  endfunction

  function automatic cmd_t noise_cmd();
    if ($urandom_range(1) == 0)
      return make_cmd(ActNone, $urandom_range(15), $urandom_range(15), dist_t'($urandom),
                      pred_t'($urandom_range(31)));
    return make_cmd(ACT_READ, $urandom_range(15), $urandom_range(15), dist_t'($urandom),
                    pred_t'($urandom_range(31)));
  endfunction

  // Offer one command and hold it until the transfer; predictor runs on acceptance
  task automatic send_cmd(input cmd_t c, input bit typed = 1'b0, input result_t want = '0);
    result_t got;
    bit      has;
    while ($urandom_range(99) < sender_gap_pct()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_action  <= c.action;
    in_row     <= c.row;
    in_col     <= c.col;
    in_cost    <= c.cost;
    in_pred_in <= c.pred;
    do @(posedge clk); while (!in_ready);
    has = predict_command(c, got);
    if (has) pending_results.push_back(typed ? want : got);
    if (c.action != ActNone) items_sent++;
    if (c.action == ACT_RUN) runs_sent++;
  endtask

  // Drop valid, wait for every expected result, then let trailing loads land
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (IdleSettle) @(posedge clk);
  endtask

  // One APB transfer: setup, access, then psel dropped before returning
  task automatic cfg_access(input bit wr, input logic [PdataW-1:0] data,
                            output logic [PdataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= NodeCountAddr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_node_count(input int nc);
    logic [PdataW-1:0] rd;
    cfg_access(1'b1, PdataW'(nc), rd);
    node_cfg = 5'(nc);
    settings_used++;
    cfg_access(1'b0, '0, rd);
    if (rd !== PdataW'(node_cfg))
      report_mismatch($sformatf("node_count readback %0d, wrote %0d", rd, node_cfg));
  endtask

  // Receiver: random backpressure per idle mode
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= receiver_stall_pct());
  end

  // Result checker: each transfer against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d dist=%0d pred=%0d",
                                  out_result_kind, out_distance, out_predecessor));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_result_kind !== want.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", out_result_kind, want.kind));
        if (out_distance !== want.distance)
          report_mismatch($sformatf("distance %0d, expected %0d", out_distance,
                                    want.distance));
        if (out_predecessor !== want.pred)
          report_mismatch($sformatf("predecessor %0d, expected %0d", out_predecessor,
                                    want.pred));
      end
    end
  end

  // Watchdog: too long without any transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("Timeout after %0d cycles without a transfer", quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [PdataW-1:0] rd;
    int nc;
    int n_eff;
    int sess;
    int r;
    int c;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset value of node_count
    cfg_access(1'b0, '0, rd);
    if (rd !== PdataW'(MaxNodes))
      report_mismatch($sformatf("node_count after reset %0d, expected %0d", rd, MaxNodes));

    // Write every entry first so nothing undefined is ever read or relaxed
    for (int i = 0; i < MaxNodes; i++)
      for (int j = 0; j < MaxNodes; j++)
        send_cmd(make_cmd(ACT_LOAD, i, j, NoEdge, '0));

    // Directed table: extremes, diagonal, unused code, a small closure
    add_step(ACT_LOAD, 0, 1, DistHi, 5'd1);
    add_step(ACT_READ, 0, 1, '0, '0, 1'b1, KIND_READ, DistHi, 5'd1);
    add_step(ACT_LOAD, 0, 2, DistLo, 5'd16);
    add_step(ACT_READ, 0, 2, '0, '0, 1'b1, KIND_READ, DistLo, 5'd16);
    add_step(ACT_LOAD, 3, 3, 32'sd12345, 5'd4);
    add_step(ACT_READ, 3, 3, '0, '0, 1'b1, KIND_READ, '0, 5'd4);
    add_step(ACT_LOAD, 15, 15, -32'sd1, 5'd31);
    add_step(ACT_READ, 15, 15, '0, '0, 1'b1, KIND_READ, '0, 5'd31);
    add_step(ACT_LOAD, 15, 0, -32'sd1, 5'd0);
    add_step(ACT_READ, 15, 0, '0, '0, 1'b1, KIND_READ, -32'sd1, 5'd0);
    add_step(ActNone, 7, 9, 32'sd77, 5'd3);
    add_step(ACT_LOAD, 0, 1, 32'sd3, 5'd1);
    add_step(ACT_LOAD, 1, 2, 32'sd4, 5'd2);
    add_step(ACT_LOAD, 0, 2, 32'sd10, 5'd1);
    add_step(ACT_LOAD, 2, 0, NoEdge, 5'd3);
    add_step(ACT_RUN, 0, 0, '0, '0, 1'b1, KIND_RUN, '0, '0);
    add_step(ACT_READ, 0, 2, '0, '0);
    add_step(ACT_READ, 1, 2, '0, '0);
    add_step(ACT_READ, 15, 1, '0, '0);
    add_step(ACT_READ, 0, 0, '0, '0);
    idle_mode = 3;
    foreach (directed_steps[s])
      send_cmd(directed_steps[s].cmd, directed_steps[s].typed, directed_steps[s].want);

    // Random graphs: configure, load the used block, close, read back
    sess = 0;
    while (items_sent < ItemTarget) begin
      idle_mode = (sess / 3) % 4;
      wait_idle();
      case (sess)
        0: nc = 1;
        1: nc = 0;
        2: nc = 16;
        3: nc = 31;
        4: nc = 2;
        default: nc = ($urandom_range(19) == 0) ? 16 : $urandom_range(6, 1);
      endcase
      program_node_count(nc);
      n_eff = (nc > MaxNodes) ? MaxNodes : nc;

      for (int i = 0; i < n_eff; i++) begin
        for (int j = 0; j < n_eff; j++) begin
          if ($urandom_range(99) < 4) send_cmd(noise_cmd());
          send_cmd(graph_entry(i, j));
        end
      end
      if (n_eff == 0) send_cmd(noise_cmd());

      // Hold the sender until the core has drained before some closures
      if (sess % 5 == 2) wait_idle();
      send_cmd(make_cmd(ACT_RUN, $urandom_range(15), $urandom_range(15),
                        dist_t'($urandom), pred_t'($urandom_range(31))));

      repeat ($urandom_range(8, 3)) begin
        if (n_eff > 0 && $urandom_range(9) != 0) begin
          r = $urandom_range(n_eff - 1);
          c = $urandom_range(n_eff - 1);
        end else begin
          r = $urandom_range(15);
          c = $urandom_range(15);
        end
        send_cmd(make_cmd(ACT_READ, r, c, dist_t'($urandom), pred_t'($urandom_range(31))));
      end
      sess++;
    end

    wait_idle();
    repeat (EndWait) @(posedge clk);

    $display("Covered %0d commands incl. %0d closure runs over %0d node_count settings",
             items_sent, runs_sent, settings_used);
    $display("Checked %0d results, %0d mismatches", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
